### rtl/d8_inflow_neighbor_mask_defines.svh
// Assertion macros for the D8 inflow neighbor mask block.
// Used by d8_inflow_neighbor_mask.sv; expects clk and rst_n in scope.
`ifndef D8_INFLOW_NEIGHBOR_MASK_DEFINES_SVH
`define D8_INFLOW_NEIGHBOR_MASK_DEFINES_SVH

// Checked on every rising edge outside reset.
`define D8INM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define D8INM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/d8inm_pkg.sv
// Shared types and constants for the D8 inflow neighbor mask block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package d8inm_pkg;

  // Default line store and frame limits (padded, border ring included)
  localparam int DEF_MAX_PADDED_COLS = 1024;
  localparam int DEF_MAX_PADDED_ROWS = 1024;

  // Field widths
  localparam int CODE_W = 16;
  localparam int DIM_W  = 10;
  localparam int MASK_W = 8;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INTERIOR_COLS = 2'd0,
    CFG_INTERIOR_ROWS = 2'd1,
    CFG_NODATA_CODE   = 2'd2
  } cfg_idx_t;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_INTERIOR_COLS = 10'd1022;
  localparam logic [DIM_W-1:0]  RST_INTERIOR_ROWS = 10'd1022;
  localparam logic [CODE_W-1:0] RST_NODATA_CODE   = 16'hD8F1;  // -9999

  // D8 direction codes, clockwise from north
  localparam logic [CODE_W-1:0] DIR_NONE = 16'd0;
  localparam logic [CODE_W-1:0] DIR_N    = 16'd1;
  localparam logic [CODE_W-1:0] DIR_NE   = 16'd2;
  localparam logic [CODE_W-1:0] DIR_E    = 16'd3;
  localparam logic [CODE_W-1:0] DIR_SE   = 16'd4;
  localparam logic [CODE_W-1:0] DIR_S    = 16'd5;
  localparam logic [CODE_W-1:0] DIR_SW   = 16'd6;
  localparam logic [CODE_W-1:0] DIR_W    = 16'd7;
  localparam logic [CODE_W-1:0] DIR_NW   = 16'd8;

endpackage

`default_nettype wire

### rtl/d8_inflow_neighbor_mask.sv
// D8 inflow neighbor mask: top level with line stores, 3x3 window and result register.
// Depends on d8inm_pkg and d8_inflow_neighbor_mask_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one padded raster cell (border ring included, north row first) per
// clock while in_tready is high and gives, for every interior cell, the
// mask and count of neighbors draining into it plus its own code. A result
// is built once the item at the south-east of its centre is taken; both
// line memories are read into registers at accept, and as that item leaves
// the window stage the window shifts, classifies and loads the output
// register. Each line memory does one read (at accept) and one write per
// cycle; consecutive items always touch different columns, so no
// forwarding is needed. The line memories are not cleared after reset.
// Border cells are stored as no-flow. in_tready drops only while a result
// waits in the output register and the window-stage item has one too.
module d8_inflow_neighbor_mask
  import d8inm_pkg::*;
#(
  parameter int MAX_PADDED_COLS = DEF_MAX_PADDED_COLS,
  parameter int MAX_PADDED_ROWS = DEF_MAX_PADDED_ROWS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [15:0] direction_code
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,  // [9:0] cell_row, [19:10] cell_col,
                                             // [35:20] centre_code,
                                             // [43:36] inflow_mask,
                                             // [47:44] inflow_count
  output logic                   out_tlast   // frame_last
);

  `include "d8_inflow_neighbor_mask_defines.svh"

  localparam int CW  = $clog2(MAX_PADDED_COLS);
  localparam int RW  = $clog2(MAX_PADDED_ROWS);
  localparam int CEW = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int REW = ((RW > DIM_W) ? RW : DIM_W) + 1;

  // Configuration registers
  logic [DIM_W-1:0]  cols_cfg_r;
  logic [DIM_W-1:0]  rows_cfg_r;
  logic [CODE_W-1:0] nodata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= RST_INTERIOR_COLS;
      rows_cfg_r <= RST_INTERIOR_ROWS;
      nodata_r   <= RST_NODATA_CODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERIOR_COLS: cols_cfg_r <= cfg_wdata[DIM_W-1:0];
        CFG_INTERIOR_ROWS: rows_cfg_r <= cfg_wdata[DIM_W-1:0];
        CFG_NODATA_CODE:   nodata_r   <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Last padded column and row index after clamping the interior size
  logic [CEW-1:0] cols_ext, cols_clamp;
  logic [REW-1:0] rows_ext, rows_clamp;
  logic [CW-1:0]  last_c;
  logic [RW-1:0]  last_r;

  always_comb begin
    cols_ext = CEW'(cols_cfg_r);
    rows_ext = REW'(rows_cfg_r);
    if (cols_ext == '0) cols_clamp = CEW'(1);
    else if (cols_ext > CEW'(MAX_PADDED_COLS - 2)) cols_clamp = CEW'(MAX_PADDED_COLS - 2);
    else cols_clamp = cols_ext;
    if (rows_ext == '0) rows_clamp = REW'(1);
    else if (rows_ext > REW'(MAX_PADDED_ROWS - 2)) rows_clamp = REW'(MAX_PADDED_ROWS - 2);
    else rows_clamp = rows_ext;
    last_c = CW'(cols_clamp + CEW'(1));
    last_r = RW'(rows_clamp + REW'(1));
  end

  // Position counters and per-item flags at accept
  logic          in_acc;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          border, has_res, is_last;
  logic [CEW-1:0] col_m1;
  logic [REW-1:0] row_m1;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    border  = (row_r == '0) || (col_r == '0) || (row_r >= last_r) || (col_r >= last_c);
    has_res = (row_r >= RW'(2)) && (col_r >= CW'(2)) && (row_r <= last_r) && (col_r <= last_c);
    is_last = (row_r == last_r) && (col_r == last_c);
    col_m1  = CEW'(col_r) - CEW'(1);
    row_m1  = REW'(row_r) - REW'(1);
    if (col_r >= last_c) begin
      col_nxt = '0;
      row_nxt = (row_r >= last_r) ? '0 : row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = (row_r > last_r) ? '0 : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Window stage: item whose line reads are in flight
  logic              s1_valid_r, s1_res_r, s1_last_r, s1_adv;
  logic [CW-1:0]     s1_addr_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [DIM_W-1:0]  s1_row_r, s1_col_r;
  logic              out_valid_r;

  assign s1_adv    = s1_valid_r && (!s1_res_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_tready) s1_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r  <= has_res;
      s1_last_r <= is_last;
      s1_addr_r <= col_r;
      s1_code_r <= border ? DIR_NONE : in_tdata;
      s1_row_r  <= row_m1[DIM_W-1:0];
      s1_col_r  <= col_m1[DIM_W-1:0];
    end
  end

  // Line memories: read at accept, written back when the item leaves the window stage
  logic [CODE_W-1:0] older_mem [MAX_PADDED_COLS];
  logic [CODE_W-1:0] newer_mem [MAX_PADDED_COLS];
  logic [CODE_W-1:0] older_rd_r, newer_rd_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      older_rd_r <= older_mem[col_r];
      newer_rd_r <= newer_mem[col_r];
    end
    if (s1_adv) begin
      older_mem[s1_addr_r] <= newer_rd_r;
      newer_mem[s1_addr_r] <= s1_code_r;
    end
  end

  // 3x3 window: two stored columns, third column from the line reads and the window-stage code
  logic [CODE_W-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_adv) begin
      win_r[0] <= win_r[1];
      win_r[1] <= older_rd_r;
      win_r[2] <= win_r[3];
      win_r[3] <= newer_rd_r;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_code_r;
    end
  end

  // Neighbor classification: N, NE, E, SE, S, SW, W, NW each tested against the opposite code
  logic [MASK_W-1:0] mask;
  logic [CNT_W-1:0]  cnt;

  always_comb begin
    mask[0] = (win_r[1]   == DIR_S)  && (win_r[1]   != nodata_r);
    mask[1] = (older_rd_r == DIR_SW) && (older_rd_r != nodata_r);
    mask[2] = (newer_rd_r == DIR_W)  && (newer_rd_r != nodata_r);
    mask[3] = (s1_code_r  == DIR_NW) && (s1_code_r  != nodata_r);
    mask[4] = (win_r[5]   == DIR_N)  && (win_r[5]   != nodata_r);
    mask[5] = (win_r[4]   == DIR_NE) && (win_r[4]   != nodata_r);
    mask[6] = (win_r[2]   == DIR_E)  && (win_r[2]   != nodata_r);
    mask[7] = (win_r[0]   == DIR_SE) && (win_r[0]   != nodata_r);
    cnt = '0;
    for (int k = 0; k < MASK_W; k++) cnt = cnt + CNT_W'(mask[k]);
  end

  // Output register
  logic [47:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s1_adv && s1_res_r) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res_r) begin
      out_data_r <= {cnt, mask, win_r[3], s1_col_r, s1_row_r};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The window stage only holds when a result is parked and not taken
  `D8INM_ASSERT(a_s1_stall_cause,
    (s1_valid_r && !s1_adv) |-> (out_valid_r && !out_tready && s1_res_r),
    "window stage stalled without a blocked result")

  // A line read never targets the column being written back in the same cycle
  `D8INM_ASSERT(a_no_line_overlap,
    (in_acc && s1_adv) |-> (col_r != s1_addr_r),
    "line memory read and write hit the same column")

  // The ready signal is high whenever the window stage is empty
  `D8INM_ASSERT_ALWAYS(a_ready_when_empty,
    !s1_valid_r |-> in_tready,
    "input stalled with empty window stage")

endmodule

`default_nettype wire
